>>> sv/ccrs_pkg.sv
// Shared types and codes for the conditional call/return stack.
// Holds the item structs, action and command codes and the default depth.
// No dependencies.
package ccrs_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int LEVEL_OUT_W     = 7;

  // Flow instruction actions
  localparam logic [2:0] ACT_CALL = 3'd0;
  localparam logic [2:0] ACT_EQ   = 3'd1;
  localparam logic [2:0] ACT_NE   = 3'd2;
  localparam logic [2:0] ACT_GT   = 3'd3;
  localparam logic [2:0] ACT_LT   = 3'd4;
  localparam logic [2:0] ACT_GE   = 3'd5;
  localparam logic [2:0] ACT_LE   = 3'd6;
  localparam logic [2:0] ACT_RET  = 3'd7;

  // Classified commands passed from front to back
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_CALL = 2'd1;
  localparam logic [1:0] OP_RET  = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] target_address;
    logic [15:0] current_pc;
    logic        flag_equal;
    logic        flag_greater;
    logic        flag_less;
    logic        flag_greater_equal;
    logic        flag_less_equal;
  } in_item_t;

  typedef struct packed {
    logic [15:0]            next_pc;
    logic                   pc_changed;
    logic                   halt_request;
    logic [LEVEL_OUT_W-1:0] stack_level;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] target_address;
    logic [15:0] current_pc;
  } cmd_t;

endpackage

>>> sv/conditional_call_return_stack.sv
// Conditional call/return stack, top level.
// Instantiates ccrs_front and ccrs_back; uses ccrs_pkg.
//
//   channel  | ports                      | transfer when
//   ---------+----------------------------+----------------------
//   input    | push, full, in_data        | push && !full
//   result   | empty, pop, out_data       | pop && !empty
//
// A call or a not-taken instruction is done in the back end's idle state;
// a return on a non-empty stack also passes the read state, for the
// registered read of the return slot RAM. A two-entry queue sits ahead of
// the back end; while a result waits to be popped, it fills from the front.
// Reset clears the queue, the level and the result valid flag; the slot
// RAM is not cleared, since only slots written by a call are ever read.
module conditional_call_return_stack
  import ccrs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  ccrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  ccrs_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

  a_halt_not_taken : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.halt_request && out_data.pc_changed))
    else $error("halt reported together with a pc change");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue or result register not cleared by reset");

  a_result_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result lost or changed");

endmodule

>>> sv/ccrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ccrs_front.sv
// Front end: accepts flow instructions, resolves the call condition and
// queues the classified command in a two-entry queue. Uses ccrs_pkg.
module ccrs_front
  import ccrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok;
  logic       take_ok;
  logic       taken;
  cmd_t       cls;

  always_comb begin
    unique case (in_data.action)
      ACT_CALL: taken = 1'b1;
      ACT_EQ:   taken = in_data.flag_equal;
      ACT_NE:   taken = !in_data.flag_equal;
      ACT_GT:   taken = in_data.flag_greater;
      ACT_LT:   taken = in_data.flag_less;
      ACT_GE:   taken = in_data.flag_greater_equal;
      ACT_LE:   taken = in_data.flag_less_equal;
      ACT_RET:  taken = 1'b0;
      default:  taken = 1'b0;
    endcase
    cls.target_address = in_data.target_address;
    cls.current_pc     = in_data.current_pc;
    if (in_data.action == ACT_RET) begin
      cls.op = OP_RET;
    end else if (taken) begin
      cls.op = OP_CALL;
    end else begin
      cls.op = OP_NONE;
    end
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign take_ok   = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ take_ok;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, take_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/ccrs_back.sv
// Back end: carries out queued commands on the return stack and holds
// the result register. Uses ccrs_pkg and ccrs_ram.
module ccrs_back
  import ccrs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  localparam int LW = $clog2(STACK_DEPTH);
  localparam logic [LW-1:0] TOP = LW'(STACK_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_r, state_nxt;
  logic [LW-1:0]   level_r, level_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [LW-1:0]   res_level;
  logic            out_free;
  logic            ram_we;
  logic [LW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  assign out_free      = !out_valid_r || pop;
  assign cmd_take      = cmd_valid && (state_r == ST_IDLE) && out_free;
  assign ram_raddr     = level_r - LW'(1);
  assign ram_we        = cmd_take && (cmd.op == OP_CALL);

  ccrs_ram #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (level_r),
    .wdata (cmd.current_pc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    res_level     = level_r;
    if (state_r == ST_READ) begin
      // popped pc arrives from the registered read
      out_data_nxt.next_pc      = ram_rdata;
      out_data_nxt.pc_changed   = 1'b1;
      out_data_nxt.halt_request = 1'b0;
      out_valid_nxt             = 1'b1;
      state_nxt                 = ST_IDLE;
    end else if (cmd_take) begin
      out_data_nxt.next_pc      = cmd.current_pc;
      out_data_nxt.pc_changed   = 1'b0;
      out_data_nxt.halt_request = 1'b0;
      out_valid_nxt             = 1'b1;
      unique case (cmd.op)
        OP_CALL: begin
          // top slot is overwritten without raising the level
          if (level_r != TOP) begin
            level_nxt = level_r + LW'(1);
          end
          res_level               = level_nxt;
          out_data_nxt.next_pc    = cmd.target_address;
          out_data_nxt.pc_changed = 1'b1;
        end
        OP_RET: begin
          if (level_r != '0) begin
            level_nxt     = ram_raddr;
            out_valid_nxt = 1'b0;
            state_nxt     = ST_READ;
          end else begin
            out_data_nxt.halt_request = 1'b1;
          end
        end
        default: ;
      endcase
    end
    out_data_nxt.stack_level = LEVEL_OUT_W'(res_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> test/ccrs_flow_checker.sv
`timescale 1ns / 1ps
// Checker for the conditional call/return stack: watches both queue channels,
// predicts each result from the accepted flow instructions and compares.
// Depends on ccrs_pkg for the item structs, action codes and default depth.
module ccrs_flow_checker
  import ccrs_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_data,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int MAX_REPORTS = 200;

  logic [15:0] saved_pc [DEPTH];
  int unsigned depth_level;
  out_item_t   expected_flow_q [$];
  int          fails;

  assign fail_count = fails;

  function automatic out_item_t step_flow(input in_item_t it);
    out_item_t r;
    bit        taken;
    r.next_pc      = it.current_pc;
    r.pc_changed   = 1'b0;
    r.halt_request = 1'b0;
    case (it.action)
      ACT_CALL: taken = 1'b1;
      ACT_EQ:   taken = it.flag_equal;
      ACT_NE:   taken = !it.flag_equal;
      ACT_GT:   taken = it.flag_greater;
      ACT_LT:   taken = it.flag_less;
      ACT_GE:   taken = it.flag_greater_equal;
      ACT_LE:   taken = it.flag_less_equal;
      default:  taken = 1'b0;
    endcase
    if (it.action == ACT_RET) begin
      if (depth_level > 0) begin
        depth_level--;
        r.next_pc = saved_pc[depth_level];
        saved_pc[depth_level] = '0;
        r.pc_changed = 1'b1;
      end else begin
        r.halt_request = 1'b1;
      end
    end else if (taken) begin
      // the top slot is overwritten in place; the level stops one short of DEPTH
      saved_pc[depth_level] = it.current_pc;
      if (depth_level < DEPTH - 1) depth_level++;
      r.next_pc    = it.target_address;
      r.pc_changed = 1'b1;
    end
    r.stack_level = depth_level[LEVEL_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_flow_q.delete();
      depth_level = 0;
    end else begin
      // compare before predicting: a result cannot come from the transfer at this edge
      if (pop && !empty) begin
        if (expected_flow_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result pc=%h chg=%b halt=%b lvl=%0d", $time,
                     out_data.next_pc, out_data.pc_changed, out_data.halt_request,
                     out_data.stack_level);
        end else begin
          want = expected_flow_q.pop_front();
          if (out_data !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: expected pc=%h chg=%b halt=%b lvl=%0d, got pc=%h chg=%b halt=%b lvl=%0d",
                       $time, want.next_pc, want.pc_changed, want.halt_request,
                       want.stack_level, out_data.next_pc, out_data.pc_changed,
                       out_data.halt_request, out_data.stack_level);
          end
        end
      end
      if (push && !full) expected_flow_q.push_back(step_flow(in_data));
    end
    pending <= expected_flow_q.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top of the conditional call/return stack testbench: clock, reset, flow
// instruction stimulus, result popping and the verdict.
// Depends on ccrs_pkg, conditional_call_return_stack and ccrs_flow_checker.
module tb;
  import ccrs_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {MODE_CLIMB, MODE_DROP, MODE_MIX} flow_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int hold_reqs = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always #5 clk = ~clk;

  conditional_call_return_stack i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  ccrs_flow_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Random fields; the flag that decides a conditional call is set to give 'taken'.
  function automatic in_item_t flow_item(input logic [2:0] act, input bit taken);
    in_item_t it;
    it.action         = act;
    it.target_address = 16'($urandom);
    it.current_pc     = 16'($urandom);
    {it.flag_equal, it.flag_greater, it.flag_less, it.flag_greater_equal,
     it.flag_less_equal} = 5'($urandom);
    case (act)
      ACT_EQ:  it.flag_equal         = taken;
      ACT_NE:  it.flag_equal         = !taken;
      ACT_GT:  it.flag_greater       = taken;
      ACT_LT:  it.flag_less          = taken;
      ACT_GE:  it.flag_greater_equal = taken;
      ACT_LE:  it.flag_less_equal    = taken;
      default: ;
    endcase
    return it;
  endfunction

  function automatic in_item_t pick_item(input int call_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return flow_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    if (r < 10 + call_pct)
      return flow_item(3'($urandom_range(ACT_CALL, ACT_LE)), $urandom_range(0, 99) < 90);
    return flow_item(ACT_RET, 1'b0);
  endfunction

  // Offer one item and hold it until the transfer.
  task automatic send_item(input in_item_t it);
    while (!tx_steady && $urandom_range(0, 99) < 36) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        // hold off the result side so the block fills and stalls its input
        hold_seen = hold_reqs;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= rx_steady || ($urandom_range(0, 99) >= 36);
    end
  end

  initial begin : stimulus
    in_item_t   it;
    flow_mode_t mode;
    int         len;
    int         sent;
    int         phase;
    int         call_pct;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // return on an empty stack, then an unconditional call at the field extremes
    it = flow_item(ACT_RET, 1'b0);
    it.current_pc = 16'hFFFF;
    send_item(it);
    it = flow_item(ACT_CALL, 1'b1);
    it.target_address = 16'hFFFF;
    it.current_pc     = 16'h0000;
    send_item(it);

    // each condition taken and not taken, other flags random
    for (int a = ACT_EQ; a <= ACT_LE; a++) begin
      for (int t = 1; t >= 0; t--) begin
        it = flow_item(3'(a), t[0]);
        it.target_address = t[0] ? 16'h0000 : 16'hFFFF;
        it.current_pc     = t[0] ? 16'hFFFF : 16'h0000;
        send_item(it);
      end
    end

    // unwind all seven saved pcs and run one past empty
    repeat (8) send_item(flow_item(ACT_RET, 1'b0));

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       begin mode = MODE_CLIMB; len = 240; end
        1:       begin mode = MODE_DROP;  len = 200; end
        default: begin
          mode = flow_mode_t'($urandom_range(0, 2));
          len  = $urandom_range(40, 160);
        end
      endcase
      case (mode)
        MODE_CLIMB: call_pct = 80;
        MODE_DROP:  call_pct = 10;
        default:    call_pct = 40;
      endcase
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      if (phase == 2) hold_reqs++;
      if (phase == 4) begin
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        send_item(pick_item(call_pct));
        sent++;
      end
      phase++;
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
